// ===== rtl/pidg_pkg.sv =====
// ----------------------------------------------------------------------------
// pidg_pkg
// Shared widths, register indexes, beat types and saturation helper for the
// PID drive with integral gate.
// ----------------------------------------------------------------------------
package pidg_pkg;

  localparam int ErrW   = 16;
  localparam int GainW  = 16;
  localparam int WinW   = 15;
  localparam int IntW   = 32;
  localparam int DiffW  = ErrW + 1;
  localparam int PpW    = ErrW + GainW;
  localparam int PiW    = IntW + GainW;
  localparam int PdW    = DiffW + GainW;
  localparam int SumW   = PiW + 1;
  localparam int FracW  = 8;
  localparam int QW     = SumW - FracW;
  localparam int DriveW = 8;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  localparam logic signed [DriveW-1:0] DriveMax = 8'sd127;
  localparam logic signed [DriveW-1:0] DriveMin = -8'sd127;
  localparam logic signed [QW-1:0]     QMax     = 41'sd127;
  localparam logic signed [QW-1:0]     QMin     = -41'sd127;

  typedef enum logic [1:0] {
    RegGainP  = 2'd0,
    RegGainI  = 2'd1,
    RegGainD  = 2'd2,
    RegWindow = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic        [WinW-1:0]  window;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [DiffW-1:0] diff;
    logic signed [IntW-1:0]  integ;
  } stage1_t;

  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic signed [PpW-1:0]  prod_p;
    logic signed [PiW-1:0]  prod_i;
    logic signed [PdW-1:0]  prod_d;
  } stage2_t;

  typedef struct packed {
    logic                   wr;
    logic signed [IntW-1:0] value;
  } iwr_t;

  function automatic logic signed [IntW-1:0] sat_int(input logic signed [IntW+1:0] s);
    logic [2:0] top;
    top = s[IntW+1:IntW-1];
    if (top == 3'b000 || top == 3'b111) begin
      return s[IntW-1:0];
    end else if (s[IntW+1]) begin
      return {1'b1, {(IntW-1){1'b0}}};
    end else begin
      return {1'b0, {(IntW-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/pid_drive_with_integral_gate.sv =====
// ----------------------------------------------------------------------------
// pid_drive_with_integral_gate
// PID controller with windowed integral and clamped 8-bit drive.
// ----------------------------------------------------------------------------
// One error beat is taken per clock while the output is not stalled, and one
// drive beat is returned for each, carried through the input register and
// then the result register. In windowed mode the integral recurrence is
// resolved ahead of the input register with a single saturating add, and
// the three gain multipliers, the sum, scaling and clamp sit between the
// input register and the result register. The input register holds its
// beat while the result register is full and stalled, so one more error
// beat is taken while a result waits. Gains are signed Q8.8; a zero window
// switches the integral to saturation-driven mode.
// ----------------------------------------------------------------------------
module pid_drive_with_integral_gate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pidg_pkg::AddrW-1:0]        paddr,
  input  logic [pidg_pkg::DataW-1:0]        pwdata,
  output logic [pidg_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [pidg_pkg::ErrW-1:0]  error_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pidg_pkg::DriveW-1:0] drive_out_o
);
  import pidg_pkg::*;

  cfg_t    cfg;
  iwr_t    iwr;
  stage1_t s1;
  stage2_t s2;
  logic    s1_valid, s1_ready;

  pidg_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .error_sample_i (error_sample_i),
    .iwr_i          (iwr),
    .s1_valid_o     (s1_valid),
    .s1_o           (s1),
    .s1_ready_i     (s1_ready)
  );

  pidg_mul u_mul (
    .cfg_i (cfg),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  pidg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s2_valid_i  (s1_valid),
    .s2_ready_o  (s1_ready),
    .s2_i        (s2),
    .iwr_o       (iwr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_out_o (drive_out_o)
  );

endmodule

// ===== rtl/pidg_apb.sv =====
// ----------------------------------------------------------------------------
// pidg_apb
// Configuration register file behind an APB-style slave port.
// ----------------------------------------------------------------------------
module pidg_apb (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pidg_pkg::AddrW-1:0] paddr,
  input  logic [pidg_pkg::DataW-1:0] pwdata,
  output logic [pidg_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output pidg_pkg::cfg_t            cfg_o
);
  import pidg_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegGainP:  cfg_q.gain_p <= pwdata[GainW-1:0];
        RegGainI:  cfg_q.gain_i <= pwdata[GainW-1:0];
        RegGainD:  cfg_q.gain_d <= pwdata[GainW-1:0];
        RegWindow: cfg_q.window <= pwdata[WinW-1:0];
        default:   cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegGainP:  prdata = {{(DataW-GainW){cfg_q.gain_p[GainW-1]}}, cfg_q.gain_p};
      RegGainI:  prdata = {{(DataW-GainW){cfg_q.gain_i[GainW-1]}}, cfg_q.gain_i};
      RegGainD:  prdata = {{(DataW-GainW){cfg_q.gain_d[GainW-1]}}, cfg_q.gain_d};
      RegWindow: prdata = {{(DataW-WinW){1'b0}}, cfg_q.window};
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/pidg_front.sv =====
// ----------------------------------------------------------------------------
// pidg_front
// Input stage: gates the integral, forms the difference term and holds the
// integral, previous error and primed flag.
// ----------------------------------------------------------------------------
module pidg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pidg_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [pidg_pkg::ErrW-1:0] error_sample_i,
  input  pidg_pkg::iwr_t              iwr_i,
  output logic                        s1_valid_o,
  output pidg_pkg::stage1_t           s1_o,
  input  logic                        s1_ready_i
);
  import pidg_pkg::*;

  logic signed [IntW-1:0]  integ_q, integ_d;
  logic signed [ErrW-1:0]  last_q;
  logic                    primed_q;
  logic                    s1_valid_q;
  stage1_t                 s1_q, s1_d;

  logic signed [ErrW:0]    err_x;
  logic        [ErrW:0]    mag;
  logic        [ErrW:0]    win_x;
  logic                    lt_win, le_win, accept;
  logic signed [IntW+1:0]  sum_one, sum_two;
  logic signed [IntW-1:0]  err_ext;
  logic signed [DiffW-1:0] diff;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  always_comb begin
    err_x   = {error_sample_i[ErrW-1], error_sample_i};
    mag     = err_x[ErrW] ? 17'(-err_x) : 17'(err_x);
    win_x   = {{(ErrW+1-WinW){1'b0}}, cfg_i.window};
    lt_win  = mag < win_x;
    le_win  = mag <= win_x;
    err_ext = {{(IntW-ErrW){error_sample_i[ErrW-1]}}, error_sample_i};
    sum_one = {{2{integ_q[IntW-1]}}, integ_q}
            + {{(IntW+2-ErrW){error_sample_i[ErrW-1]}}, error_sample_i};
    sum_two = {{2{integ_q[IntW-1]}}, integ_q}
            + {{(IntW+1-ErrW){error_sample_i[ErrW-1]}}, error_sample_i, 1'b0};
    diff    = err_x - {last_q[ErrW-1], last_q};

    s1_d.err   = error_sample_i;
    s1_d.diff  = primed_q ? diff : '0;
    s1_d.integ = lt_win ? sat_int(sum_one) : '0;

    integ_d = integ_q;
    if (accept && cfg_i.window != '0) begin
      if (lt_win) begin
        integ_d = sat_int(sum_two);
      end else if (le_win) begin
        integ_d = err_ext;
      end else begin
        integ_d = '0;
      end
    end else if (iwr_i.wr) begin
      integ_d = iwr_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_q     <= '0;
      primed_q   <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      integ_q <= integ_d;
      if (accept) begin
        last_q   <= error_sample_i;
        primed_q <= 1'b1;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

endmodule

// ===== rtl/pidg_mul.sv =====
// ----------------------------------------------------------------------------
// pidg_mul
// Product stage: three parallel gain multipliers between the input register
// and the result stage.
// ----------------------------------------------------------------------------
module pidg_mul (
  input  pidg_pkg::cfg_t    cfg_i,
  input  pidg_pkg::stage1_t s1_i,
  output pidg_pkg::stage2_t s2_o
);
  import pidg_pkg::*;

  always_comb begin
    s2_o.err    = s1_i.err;
    s2_o.prod_p = $signed(s1_i.err) * $signed(cfg_i.gain_p);
    s2_o.prod_i = $signed(s1_i.integ) * $signed(cfg_i.gain_i);
    s2_o.prod_d = $signed(s1_i.diff) * $signed(cfg_i.gain_d);
  end

endmodule

// ===== rtl/pidg_back.sv =====
// ----------------------------------------------------------------------------
// pidg_back
// Result stage: sums the terms, scales toward zero, clamps the drive and
// returns the saturation-driven integral update.
// ----------------------------------------------------------------------------
module pidg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pidg_pkg::cfg_t                cfg_i,
  input  logic                          s2_valid_i,
  output logic                          s2_ready_o,
  input  pidg_pkg::stage2_t             s2_i,
  output pidg_pkg::iwr_t                iwr_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [pidg_pkg::DriveW-1:0] drive_out_o
);
  import pidg_pkg::*;

  logic                     out_valid_q;
  logic signed [DriveW-1:0] drive_q, drive_d;
  logic signed [SumW-1:0]   sum, biased;
  logic signed [QW-1:0]     q;
  logic                     hit, advance;

  assign s2_ready_o  = !out_valid_q || out_ready_i;
  assign advance     = s2_valid_i && s2_ready_o;
  assign out_valid_o = out_valid_q;
  assign drive_out_o = drive_q;

  always_comb begin
    sum    = {{(SumW-PpW){s2_i.prod_p[PpW-1]}}, s2_i.prod_p}
           + {{(SumW-PiW){s2_i.prod_i[PiW-1]}}, s2_i.prod_i}
           + {{(SumW-PdW){s2_i.prod_d[PdW-1]}}, s2_i.prod_d};
    biased = sum + (sum[SumW-1] ? SumW'((1 << FracW) - 1) : '0);
    q      = biased[SumW-1:FracW];
    hit    = (q >= QMax) || (q <= QMin);

    if (q >= QMax) begin
      drive_d = DriveMax;
    end else if (q < QMin) begin
      drive_d = DriveMin;
    end else begin
      drive_d = q[DriveW-1:0];
    end

    iwr_o.wr    = advance && (cfg_i.window == '0);
    iwr_o.value = hit ? {{(IntW-ErrW){s2_i.err[ErrW-1]}}, s2_i.err} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready_o) begin
      out_valid_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q <= drive_d;
    end
  end

endmodule

// ===== tb/pid_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the register port and both beat channels of the PID drive block.
// Shadows the gains and the integral window from register writes and checks
// register reads against them. Keeps its own integral, last error and primed
// flag, works out the clamped drive for every accepted error beat, and
// compares each accepted drive beat with the oldest one waiting.
// ----------------------------------------------------------------------------
module pid_drive_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pidg_pkg::AddrW-1:0]         paddr,
  input  logic [pidg_pkg::DataW-1:0]         pwdata,
  input  logic [pidg_pkg::DataW-1:0]         prdata,
  input  logic                               pready,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic signed [pidg_pkg::ErrW-1:0]   error_sample_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [pidg_pkg::DriveW-1:0] drive_out_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import pidg_pkg::*;

  localparam longint IntHi = 64'sd2147483647;
  localparam longint IntLo = -64'sd2147483648;

  cfg_t                    cfg_shadow = '0;
  logic signed [IntW-1:0]  integ_acc  = '0;
  logic signed [ErrW-1:0]  prev_err   = '0;
  logic                    seen_err   = 1'b0;
  logic signed [DriveW-1:0] drive_expected_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic signed [IntW-1:0] sat_sum(input longint s);
    if (s > IntHi) begin
      return IntHi[IntW-1:0];
    end else if (s < IntLo) begin
      return IntLo[IntW-1:0];
    end
    return s[IntW-1:0];
  endfunction

  function automatic logic signed [DriveW-1:0] next_drive(input logic signed [ErrW-1:0] err);
    longint e;
    longint mag;
    longint win;
    longint d;
    longint sum;
    longint q;
    longint qmag;
    logic signed [DriveW-1:0] drv;
    e   = longint'(err);
    mag = (e < 0) ? -e : e;
    win = longint'(cfg_shadow.window);

    if (mag < win) begin
      integ_acc = sat_sum(longint'(integ_acc) + e);
    end else begin
      integ_acc = '0;
    end

    d = seen_err ? e - longint'(prev_err) : 0;

    sum = e * longint'(cfg_shadow.gain_p)
        + longint'(integ_acc) * longint'(cfg_shadow.gain_i)
        + d * longint'(cfg_shadow.gain_d);
    q    = sum / 256;
    qmag = (q < 0) ? -q : q;

    if (win != 0) begin
      if (mag <= win) begin
        integ_acc = sat_sum(longint'(integ_acc) + e);
      end else begin
        integ_acc = '0;
      end
    end else begin
      if (qmag >= longint'(DriveMax)) begin
        integ_acc = sat_sum(longint'(integ_acc) + e);
      end else begin
        integ_acc = '0;
      end
    end

    if (q >= longint'(DriveMax)) begin
      drv = DriveMax;
    end else if (q < longint'(DriveMin)) begin
      drv = DriveMin;
    end else begin
      drv = q[DriveW-1:0];
    end

    prev_err = err;
    seen_err = 1'b1;
    return drv;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [DriveW-1:0] want;
    reg_idx_e                 idx;
    if (!rst_ni) begin
      cfg_shadow = '0;
      integ_acc  = '0;
      prev_err   = '0;
      seen_err   = 1'b0;
      drive_expected_q.delete();
      pending_o  = 0;
    end else begin
      idx = reg_idx_e'(paddr[3:2]);
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            RegGainP:  cfg_shadow.gain_p = pwdata[GainW-1:0];
            RegGainI:  cfg_shadow.gain_i = pwdata[GainW-1:0];
            RegGainD:  cfg_shadow.gain_d = pwdata[GainW-1:0];
            RegWindow: cfg_shadow.window = pwdata[WinW-1:0];
            default: ;
          endcase
        end else begin
          case (idx)
            RegGainP: begin
              if (prdata[GainW-1:0] !== cfg_shadow.gain_p) begin
                $error("gain_p: expected %0h, got %0h", cfg_shadow.gain_p, prdata[GainW-1:0]);
                fail_count_o++;
              end
            end
            RegGainI: begin
              if (prdata[GainW-1:0] !== cfg_shadow.gain_i) begin
                $error("gain_i: expected %0h, got %0h", cfg_shadow.gain_i, prdata[GainW-1:0]);
                fail_count_o++;
              end
            end
            RegGainD: begin
              if (prdata[GainW-1:0] !== cfg_shadow.gain_d) begin
                $error("gain_d: expected %0h, got %0h", cfg_shadow.gain_d, prdata[GainW-1:0]);
                fail_count_o++;
              end
            end
            RegWindow: begin
              if (prdata[WinW-1:0] !== cfg_shadow.window) begin
                $error("integral_window: expected %0h, got %0h", cfg_shadow.window,
                       prdata[WinW-1:0]);
                fail_count_o++;
              end
            end
            default: ;
          endcase
        end
      end

      if (in_valid_i && in_ready_i) begin
        drive_expected_q.push_back(next_drive(error_sample_i));
      end

      if (out_valid_i && out_ready_i) begin
        if (drive_expected_q.size() == 0) begin
          $error("drive_out: expected no beat, got %0d", drive_out_i);
          fail_count_o++;
        end else begin
          want = drive_expected_q.pop_front();
          if (drive_out_i !== want) begin
            $error("drive_out: expected %0d, got %0d", want, drive_out_i);
            fail_count_o++;
          end
        end
      end
      pending_o = drive_expected_q.size();
    end
  end

endmodule

// ===== tb/pid_drive_with_integral_gate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_drive_with_integral_gate_tb
// Drives error beats in bursts and stalls the drive channel on its own
// pattern. A directed part covers the first sample after reset, the clamp
// boundaries, the window edges and the gain extremes; a short gapless soak
// pushes the accumulator up and back down; random phases then mix gains,
// windows and errors. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module pid_drive_with_integral_gate_tb;
  import pidg_pkg::*;

  localparam int StallLimit = 2000;
  localparam int SoakBeats  = 40;
  localparam int RandPhases = 6;
  localparam int PhaseBeats = 105;

  typedef enum int {
    RxOpen,
    RxCoin,
    RxStallRuns
  } rx_mode_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [AddrW-1:0]          paddr;
  logic [DataW-1:0]          pwdata;
  logic [DataW-1:0]          prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [ErrW-1:0]    error_sample_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [DriveW-1:0]  drive_out_o;

  int fail_count;
  int pending;
  int burst_left;
  int idle_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  pid_drive_with_integral_gate u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .error_sample_i (error_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_out_o    (drive_out_o)
  );

  pid_drive_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .error_sample_i (error_sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_out_i    (drive_out_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // stall the drive channel
  initial begin : rx_pattern
    rx_mode_e mode;
    int       run;
    int       hold;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 2));
      run  = $urandom_range(16, 160);
      repeat (run) begin
        @(negedge clk_i);
        case (mode)
          RxOpen: out_ready_i = 1'b1;
          RxCoin: out_ready_i = 1'($urandom_range(0, 1));
          default: begin
            if (hold > 0) begin
              hold--;
              out_ready_i = 1'b0;
            end else begin
              out_ready_i = 1'b1;
              if ($urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 12);
              end
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic signed [ErrW-1:0] err);
    if (burst_left <= 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(60, 200);
      end else begin
        burst_left = $urandom_range(1, 24);
      end
    end
    in_valid_i     = 1'b1;
    error_sample_i = err;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic reg_access(input reg_idx_e idx, input logic wr, input logic [DataW-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_gains(input logic signed [GainW-1:0] kp, input logic signed [GainW-1:0] ki,
                            input logic signed [GainW-1:0] kd, input logic [WinW-1:0] win);
    drain();
    reg_access(RegGainP, 1'b1, {16'($urandom), kp});
    reg_access(RegGainI, 1'b1, {16'($urandom), ki});
    reg_access(RegGainD, 1'b1, {16'($urandom), kd});
    reg_access(RegWindow, 1'b1, {17'($urandom), win});
    reg_access(RegGainP, 1'b0, '0);
    reg_access(RegGainI, 1'b0, '0);
    reg_access(RegGainD, 1'b0, '0);
    reg_access(RegWindow, 1'b0, '0);
  endtask

  function automatic logic signed [GainW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return '0;
      3:       return 16'($urandom_range(0, 1023) - 512);
      4:       return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'sd256 : -16'sd256;
    endcase
  endfunction

  function automatic logic [WinW-1:0] pick_window();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 15'h7fff;
      2:       return 15'($urandom_range(1, 300));
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic logic signed [ErrW-1:0] pick_error(input int win);
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($signed(16'($urandom)));
      1: v = $urandom_range(0, 600) - 300;
      2: begin
        v = win + $urandom_range(0, 2) - 1;
        if (v > 32767) begin
          v = 32767;
        end
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       v = 32767;
          1:       v = -32768;
          default: v = 0;
        endcase
      end
    endcase
    return v[ErrW-1:0];
  endfunction

  initial begin : stimulus
    int                     prime_errs[4]  = '{100, 100, -27, 100};
    int                     clamp_errs[11] = '{0, 126, 127, 128, -126, -127, -128,
                                               32767, -32768, 1, -1};
    int                     window_errs[7] = '{50, 99, 100, -100, 101, 0, -99};
    int                     gain_errs[4]   = '{32767, -32768, 32767, -32768};
    logic [WinW-1:0]        win;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    error_sample_i = '0;
    burst_left     = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    load_gains(16'sd0, 16'sd0, 16'sd256, 15'd0);
    foreach (prime_errs[k]) send_beat(16'(prime_errs[k]));
    load_gains(16'sd256, 16'sd0, 16'sd0, 15'd0);
    foreach (clamp_errs[k]) send_beat(16'(clamp_errs[k]));
    load_gains(16'sd0, 16'sd256, 16'sd0, 15'd100);
    foreach (window_errs[k]) send_beat(16'(window_errs[k]));
    load_gains(16'sd32767, -16'sd32768, -16'sd32768, 15'h7fff);
    foreach (gain_errs[k]) send_beat(16'(gain_errs[k]));

    // push the integral up and back down without gaps
    load_gains(16'sd0, 16'sd1, 16'sd0, 15'h7fff);
    burst_left = 3 * SoakBeats;
    repeat (SoakBeats) send_beat(16'sd32766);
    send_beat(-16'sd32768);
    repeat (SoakBeats) send_beat(-16'sd32766);
    burst_left = 0;

    repeat (RandPhases) begin
      win = pick_window();
      load_gains(pick_gain(), pick_gain(), pick_gain(), win);
      repeat (PhaseBeats) begin
        if ($urandom_range(0, 79) == 0) begin
          drain();
        end
        send_beat(pick_error(int'(win)));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
